[rtl/cc20_pkg.sv]
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and helpers for the ChaCha20 keystream XOR block.
// ----------------------------------------------------------------------------
package cc20_pkg;

    localparam int WORD_W     = 32;
    localparam int WORDS      = 16;
    localparam int WORD_IDX_W = 4;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW_A  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW_B  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH_A = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH_B = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_NONCE      = 3'd4;

    localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

    typedef struct packed {
        logic [63:0] key_low_a;
        logic [63:0] key_low_b;
        logic [63:0] key_high_a;
        logic [63:0] key_high_b;
        logic [63:0] nonce;
    } cc20_cfg_t;

    typedef struct packed {
        logic start;
        logic abort;
    } cc20_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cc20_sts_t;

    typedef struct packed {
        logic                  en;
        logic [WORD_IDX_W-1:0] addr;
        logic [WORD_W-1:0]     data;
    } cc20_ks_wr_t;

    typedef enum logic [2:0] {
        CC_IDLE,
        CC_INIT,
        CC_RD,
        CC_CAP,
        CC_ARX,
        CC_WB,
        CC_FEED
    } cc20_state_t;

    // Word index of operand k (a, b, c, d) of quarter round qr.
    // qr[2] selects the diagonal round; operand k sits in row k of the 4x4 state.
    function automatic logic [WORD_IDX_W-1:0] qr_index(input logic [2:0] qr,
                                                       input logic [1:0] k);
        logic [1:0] col;
        col = qr[2] ? (qr[1:0] + k) : qr[1:0];
        return {k, col};
    endfunction

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] init_word(input cc20_cfg_t cfg,
                                                    input logic [63:0] counter,
                                                    input logic [WORD_IDX_W-1:0] idx);
        logic [WORD_W-1:0] w;
        case (idx)
            4'd0:    w = SIGMA_0;
            4'd1:    w = SIGMA_1;
            4'd2:    w = SIGMA_2;
            4'd3:    w = SIGMA_3;
            4'd4:    w = cfg.key_low_a[31:0];
            4'd5:    w = cfg.key_low_a[63:32];
            4'd6:    w = cfg.key_low_b[31:0];
            4'd7:    w = cfg.key_low_b[63:32];
            4'd8:    w = cfg.key_high_a[31:0];
            4'd9:    w = cfg.key_high_a[63:32];
            4'd10:   w = cfg.key_high_b[31:0];
            4'd11:   w = cfg.key_high_b[63:32];
            4'd12:   w = counter[31:0];
            4'd13:   w = counter[63:32];
            4'd14:   w = cfg.nonce[31:0];
            default: w = cfg.nonce[63:32];
        endcase
        return w;
    endfunction

endpackage

[rtl/chacha20_keystream_xor.sv]
// Path: a byte accepted while a keystream block holds unused bytes reaches m_tdata
//   via p1_byte_reg and out_data_reg; the first byte after reset or a register write
//   waits for a block. Throughput: one byte per cycle while the block lasts and the
//   output is not stalled; no byte is taken while each new block is made, one quarter
//   round at a time over the work RAM's single read and single write port.
// Reset (aresetn low, synchronous): registers, counter and stream position go to zero.
// ----------------------------------------------------------------------------
// chacha20_keystream_xor
// ChaCha20 (64-bit nonce, 64-bit counter) byte stream XOR with register port.
// ----------------------------------------------------------------------------
module chacha20_keystream_xor #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_in
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] data_out
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cc20_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [63:0]                     cfg_data
);

    cc20_pkg::cc20_cfg_t   cfg_reg;
    cc20_pkg::cc20_ctl_t   ctl;
    cc20_pkg::cc20_sts_t   sts;
    cc20_pkg::cc20_ks_wr_t ks_wr;

    logic [63:0] counter_reg;
    logic [5:0]  pos_reg;
    logic        ks_ready_reg;
    logic        p1_valid_reg;
    logic [7:0]  p1_byte_reg;
    logic [1:0]  p1_sel_reg;
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;

    logic        cfg_wr;
    logic        s_acc;
    logic        p1_adv;
    logic [cc20_pkg::WORD_W-1:0] ks_word;
    logic [7:0]  ks_byte;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready && (cfg_addr <= cc20_pkg::REG_NONCE);

    assign p1_adv   = !out_valid_reg || m_tready;
    assign s_tready = ks_ready_reg && (!p1_valid_reg || p1_adv);
    assign s_acc    = s_tvalid && s_tready;

    assign ctl.start = !ks_ready_reg && !sts.busy && !cfg_wr;
    assign ctl.abort = cfg_wr;

    cc20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .counter (counter_reg),
        .ctl     (ctl),
        .sts     (sts),
        .ks_wr   (ks_wr)
    );

    cc20_ram #(
        .WIDTH (cc20_pkg::WORD_W),
        .DEPTH (cc20_pkg::WORDS)
    ) u_ks_ram (
        .aclk    (aclk),
        .wr_en   (ks_wr.en),
        .wr_addr (ks_wr.addr),
        .wr_data (ks_wr.data),
        .rd_en   (s_acc),
        .rd_addr (pos_reg[5:2]),
        .rd_data (ks_word)
    );

    always_comb begin
        case (p1_sel_reg)
            2'd0:    ks_byte = ks_word[7:0];
            2'd1:    ks_byte = ks_word[15:8];
            2'd2:    ks_byte = ks_word[23:16];
            default: ks_byte = ks_word[31:24];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= '0;
            counter_reg   <= '0;
            pos_reg       <= '0;
            ks_ready_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                pos_reg <= pos_reg + 6'd1;
                if (pos_reg == 6'd63) begin
                    ks_ready_reg <= 1'b0;
                end
            end
            if (sts.done) begin
                counter_reg  <= counter_reg + 64'd1;
                pos_reg      <= '0;
                ks_ready_reg <= 1'b1;
            end
            if (cfg_wr) begin
                counter_reg  <= '0;
                pos_reg      <= '0;
                ks_ready_reg <= 1'b0;
                case (cfg_addr)
                    cc20_pkg::REG_KEY_LOW_A:  cfg_reg.key_low_a  <= cfg_data;
                    cc20_pkg::REG_KEY_LOW_B:  cfg_reg.key_low_b  <= cfg_data;
                    cc20_pkg::REG_KEY_HIGH_A: cfg_reg.key_high_a <= cfg_data;
                    cc20_pkg::REG_KEY_HIGH_B: cfg_reg.key_high_b <= cfg_data;
                    default:                  cfg_reg.nonce      <= cfg_data;
                endcase
            end

            if (s_acc) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end

            if (p1_valid_reg && p1_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_byte_reg <= s_tdata;
            p1_sel_reg  <= pos_reg[1:0];
        end
        if (p1_valid_reg && p1_adv) begin
            out_data_reg <= p1_byte_reg ^ ks_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        ks_ready_reg |-> !sts.busy)
        else $error("block generator running while keystream block in use");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (sts.done && !cfg_wr) |=> ks_ready_reg && (pos_reg == 6'd0)
                                  && (counter_reg == $past(counter_reg) + 64'd1))
        else $error("finished block not handed to the stream side");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (pos_reg == 6'd63)) |=> !ks_ready_reg)
        else $error("keystream block not retired after last byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_adv) |=> p1_valid_reg && $stable(p1_byte_reg)
                                      && $stable(ks_word))
        else $error("in-flight beat lost while output stalled");

endmodule

[rtl/cc20_ram.sv]
// ----------------------------------------------------------------------------
// cc20_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cc20_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/cc20_core.sv]
// ----------------------------------------------------------------------------
// cc20_core
// Block generator: loads the working state into a 16-word RAM, one quarter round at a
// time (read four words, four ARX steps, write four words back), then the
// feed-forward add into the keystream RAM.
// ----------------------------------------------------------------------------
module cc20_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cc20_pkg::cc20_cfg_t  cfg,
    input  logic [63:0]          counter,
    input  cc20_pkg::cc20_ctl_t  ctl,
    output cc20_pkg::cc20_sts_t  sts,
    output cc20_pkg::cc20_ks_wr_t ks_wr
);

    localparam int DR_W = $clog2(DOUBLE_ROUNDS);

    cc20_pkg::cc20_state_t state_reg, state_next;
    logic [1:0]       k_reg, k_next;
    logic [2:0]       qr_reg, qr_next;
    logic [DR_W-1:0]  dr_reg, dr_next;
    logic [4:0]       idx_reg, idx_next;

    logic [cc20_pkg::WORD_W-1:0] w_reg [4];
    logic [cc20_pkg::WORD_W-1:0] w_next [4];

    logic                              wk_wr_en;
    logic [cc20_pkg::WORD_IDX_W-1:0]   wk_wr_addr;
    logic [cc20_pkg::WORD_W-1:0]       wk_wr_data;
    logic                              wk_rd_en;
    logic [cc20_pkg::WORD_IDX_W-1:0]   wk_rd_addr;
    logic [cc20_pkg::WORD_W-1:0]       wk_rd_data;

    logic [cc20_pkg::WORD_IDX_W-1:0]   feed_idx;
    logic [cc20_pkg::WORD_W-1:0]       arx_sum;

    cc20_ram #(
        .WIDTH (cc20_pkg::WORD_W),
        .DEPTH (cc20_pkg::WORDS)
    ) u_work_ram (
        .aclk    (aclk),
        .wr_en   (wk_wr_en),
        .wr_addr (wk_wr_addr),
        .wr_data (wk_wr_data),
        .rd_en   (wk_rd_en),
        .rd_addr (wk_rd_addr),
        .rd_data (wk_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cc20_pkg::CC_IDLE;
            k_reg     <= '0;
            qr_reg    <= '0;
            dr_reg    <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            qr_reg    <= qr_next;
            dr_reg    <= dr_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            w_reg[i] <= w_next[i];
        end
    end

    assign feed_idx = cc20_pkg::WORD_IDX_W'(idx_reg - 5'd1);

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        qr_next    = qr_reg;
        dr_next    = dr_reg;
        idx_next   = idx_reg;
        for (int i = 0; i < 4; i++) begin
            w_next[i] = w_reg[i];
        end
        arx_sum    = '0;
        wk_wr_en   = 1'b0;
        wk_wr_addr = idx_reg[cc20_pkg::WORD_IDX_W-1:0];
        wk_wr_data = cc20_pkg::init_word(cfg, counter, idx_reg[cc20_pkg::WORD_IDX_W-1:0]);
        wk_rd_en   = 1'b0;
        wk_rd_addr = cc20_pkg::qr_index(qr_reg, k_reg);
        ks_wr.en   = 1'b0;
        ks_wr.addr = feed_idx;
        ks_wr.data = wk_rd_data + cc20_pkg::init_word(cfg, counter, feed_idx);
        sts.busy   = (state_reg != cc20_pkg::CC_IDLE);
        sts.done   = 1'b0;

        case (state_reg)
            cc20_pkg::CC_IDLE: begin
                if (ctl.start) begin
                    state_next = cc20_pkg::CC_INIT;
                    idx_next   = '0;
                end
            end
            cc20_pkg::CC_INIT: begin
                wk_wr_en = 1'b1;
                idx_next = idx_reg + 5'd1;
                if (idx_reg[3:0] == 4'd15) begin
                    state_next = cc20_pkg::CC_RD;
                    k_next     = '0;
                    qr_next    = '0;
                    dr_next    = '0;
                end
            end
            cc20_pkg::CC_RD: begin
                // read data comes from the RAM's read register, so it lags the address
                wk_rd_en = 1'b1;
                if (k_reg != 2'd0) begin
                    w_next[k_reg - 2'd1] = wk_rd_data;
                end
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    state_next = cc20_pkg::CC_CAP;
                end
            end
            cc20_pkg::CC_CAP: begin
                w_next[3]  = wk_rd_data;
                k_next     = '0;
                state_next = cc20_pkg::CC_ARX;
            end
            cc20_pkg::CC_ARX: begin
                case (k_reg)
                    2'd0: begin
                        arx_sum   = w_reg[0] + w_reg[1];
                        w_next[0] = arx_sum;
                        w_next[3] = cc20_pkg::rotl(w_reg[3] ^ arx_sum, 16);
                    end
                    2'd1: begin
                        arx_sum   = w_reg[2] + w_reg[3];
                        w_next[2] = arx_sum;
                        w_next[1] = cc20_pkg::rotl(w_reg[1] ^ arx_sum, 12);
                    end
                    2'd2: begin
                        arx_sum   = w_reg[0] + w_reg[1];
                        w_next[0] = arx_sum;
                        w_next[3] = cc20_pkg::rotl(w_reg[3] ^ arx_sum, 8);
                    end
                    default: begin
                        arx_sum   = w_reg[2] + w_reg[3];
                        w_next[2] = arx_sum;
                        w_next[1] = cc20_pkg::rotl(w_reg[1] ^ arx_sum, 7);
                    end
                endcase
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    state_next = cc20_pkg::CC_WB;
                end
            end
            cc20_pkg::CC_WB: begin
                // all four write-backs finish before the next quarter round reads
                wk_wr_en   = 1'b1;
                wk_wr_addr = cc20_pkg::qr_index(qr_reg, k_reg);
                wk_wr_data = w_reg[k_reg];
                k_next     = k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    qr_next    = qr_reg + 3'd1;
                    state_next = cc20_pkg::CC_RD;
                    if (qr_reg == 3'd7) begin
                        if (dr_reg == DR_W'(DOUBLE_ROUNDS - 1)) begin
                            state_next = cc20_pkg::CC_FEED;
                            idx_next   = '0;
                        end else begin
                            dr_next = dr_reg + DR_W'(1);
                        end
                    end
                end
            end
            cc20_pkg::CC_FEED: begin
                wk_rd_en   = (idx_reg != 5'd16);
                wk_rd_addr = idx_reg[cc20_pkg::WORD_IDX_W-1:0];
                ks_wr.en   = (idx_reg != 5'd0);
                idx_next   = idx_reg + 5'd1;
                if (idx_reg == 5'd16) begin
                    sts.done   = 1'b1;
                    state_next = cc20_pkg::CC_IDLE;
                end
            end
            default: begin
                state_next = cc20_pkg::CC_IDLE;
            end
        endcase

        if (ctl.abort) begin
            state_next = cc20_pkg::CC_IDLE;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cc20_pkg::CC_CAP) |=> (state_reg == cc20_pkg::CC_ARX) || $past(ctl.abort))
        else $error("capture not followed by ARX steps");

    assert property (@(posedge aclk) disable iff (!aresetn)
        sts.done |-> (state_reg == cc20_pkg::CC_FEED) && !wk_rd_en && ks_wr.en)
        else $error("done raised before last keystream word written");

    assert property (@(posedge aclk) disable iff (!aresetn)
        wk_wr_en |-> !wk_rd_en)
        else $error("work RAM read and write overlap");

endmodule

[bench/chacha20_keystream_xor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_keystream_xor_tb
// Drives byte beats through the ChaCha20 XOR stream and checks every output
// byte against an in-bench keystream generator. Key and nonce change between
// traffic phases, including all-zero and all-ones settings and writes to
// unused register indexes. Back-pressure and source gaps vary across the run.
// ----------------------------------------------------------------------------
module chacha20_keystream_xor_tb;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int RANDOM_BYTES  = 850;
    localparam int QUIET_LIMIT   = 8000;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata   = 8'h00;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [7:0]                      m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [cc20_pkg::CFG_ADDR_W-1:0] cfg_addr  = cc20_pkg::REG_KEY_LOW_A;
    logic [63:0]                     cfg_data  = 64'd0;

    chacha20_keystream_xor #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // stimulus and expectations
    logic [7:0] pending_bytes[$];
    logic [7:0] expected_cipher[$];
    int         send_idle_pct = 13;
    int         recv_idle_pct = 72;
    int         fail_count    = 0;
    int         rx_beats      = 0;
    int         quiet_cycles  = 0;

    // keystream generator state
    cc20_pkg::cc20_cfg_t shadow_cfg = '0;
    logic [63:0] blk_ctr   = 64'd0;
    logic [5:0]  ks_pos    = 6'd0;
    logic        ks_live   = 1'b0;
    logic [7:0]  ks_bytes[64];

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void fill_keystream();
        logic [31:0] st[16];
        logic [31:0] w[16];
        logic [31:0] sum;
        int a, b, c, d;
        st[0]  = cc20_pkg::SIGMA_0;
        st[1]  = cc20_pkg::SIGMA_1;
        st[2]  = cc20_pkg::SIGMA_2;
        st[3]  = cc20_pkg::SIGMA_3;
        st[4]  = shadow_cfg.key_low_a[31:0];
        st[5]  = shadow_cfg.key_low_a[63:32];
        st[6]  = shadow_cfg.key_low_b[31:0];
        st[7]  = shadow_cfg.key_low_b[63:32];
        st[8]  = shadow_cfg.key_high_a[31:0];
        st[9]  = shadow_cfg.key_high_a[63:32];
        st[10] = shadow_cfg.key_high_b[31:0];
        st[11] = shadow_cfg.key_high_b[63:32];
        st[12] = blk_ctr[31:0];
        st[13] = blk_ctr[63:32];
        st[14] = shadow_cfg.nonce[31:0];
        st[15] = shadow_cfg.nonce[63:32];
        w = st;
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            // q 0..3 column round, q 4..7 diagonal round
            for (int q = 0; q < 8; q++) begin
                a = q % 4;
                if (q < 4) begin
                    b = 4 + a;
                    c = 8 + a;
                    d = 12 + a;
                end else begin
                    b = 4 + (a + 1) % 4;
                    c = 8 + (a + 2) % 4;
                    d = 12 + (a + 3) % 4;
                end
                w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 16);
                w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 12);
                w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 8);
                w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 7);
            end
        end
        for (int i = 0; i < 16; i++) begin
            sum = w[i] + st[i];
            for (int j = 0; j < 4; j++)
                ks_bytes[4 * i + j] = sum[8 * j +: 8];
        end
        blk_ctr = blk_ctr + 64'd1;
        ks_pos  = 6'd0;
        ks_live = 1'b1;
    endfunction

    function automatic logic [7:0] cipher_byte(input logic [7:0] din);
        logic [7:0] res;
        if (!ks_live)
            fill_keystream();
        res    = din ^ ks_bytes[ks_pos];
        ks_pos = ks_pos + 6'd1;
        if (ks_pos == 6'd0)
            ks_live = 1'b0;
        return res;
    endfunction

    function automatic void apply_reg(input logic [cc20_pkg::CFG_ADDR_W-1:0] addr,
                                      input logic [63:0] data);
        case (addr)
            cc20_pkg::REG_KEY_LOW_A:  shadow_cfg.key_low_a  = data;
            cc20_pkg::REG_KEY_LOW_B:  shadow_cfg.key_low_b  = data;
            cc20_pkg::REG_KEY_HIGH_A: shadow_cfg.key_high_a = data;
            cc20_pkg::REG_KEY_HIGH_B: shadow_cfg.key_high_b = data;
            cc20_pkg::REG_NONCE:      shadow_cfg.nonce      = data;
            default:                  return;  // unused index: stream keeps going
        endcase
        blk_ctr = 64'd0;
        ks_pos  = 6'd0;
        ks_live = 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t: output beat %0d %s: expected %02h, got %02h",
                 $realtime, rx_beats, what, want, got);
        fail_count++;
    endtask

    // Call at a rising edge; leaves cfg_valid high so back-to-back writes
    // never lower and raise it in one step.
    task automatic write_reg(input logic [cc20_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(addr, data);
    endtask

    task automatic write_all(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [63:0] nv);
        write_reg(cc20_pkg::REG_KEY_LOW_A, k0);
        write_reg(cc20_pkg::REG_KEY_LOW_B, k1);
        write_reg(cc20_pkg::REG_KEY_HIGH_A, k2);
        write_reg(cc20_pkg::REG_KEY_HIGH_B, k3);
        write_reg(cc20_pkg::REG_NONCE, nv);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || s_tvalid || expected_cipher.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_cipher.push_back(cipher_byte(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_bytes.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side
    always @(posedge aclk) begin : rx_check
        logic [7:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_cipher.size() == 0) begin
                report_mismatch("arrived with nothing pending", 8'h00, m_tdata);
            end else begin
                want = expected_cipher.pop_front();
                if (m_tdata !== want)
                    report_mismatch("data_out", want, m_tdata);
            end
            rx_beats++;
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // no beat on any channel for too long means a hang
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("chacha20_keystream_xor_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : main_seq
        int sent;
        int run_len;
        int pick;
        logic [7:0] edge_bytes[8];
        edge_bytes = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h55, 8'haa, 8'h0f, 8'hf0};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all-zero key and nonce straight out of reset
        foreach (edge_bytes[i])
            pending_bytes.push_back(edge_bytes[i]);
        for (int i = 0; i < 4; i++)
            pending_bytes.push_back(rand_byte());
        drain();

        // all-ones key and nonce
        write_all('1, '1, '1, '1, '1);
        for (int i = 0; i < 8; i++)
            pending_bytes.push_back(rand_byte());
        drain();

        // unused indexes mid-block: no restart expected
        write_reg(3'd5, rand64());
        write_reg(3'd6, rand64());
        write_reg(3'd7, '1);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 5; i++)
            pending_bytes.push_back(rand_byte());
        drain();

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            if (sent < RANDOM_BYTES / 3) begin
                send_idle_pct = 13;
                recv_idle_pct = 72;
            end else if (sent < 2 * RANDOM_BYTES / 3) begin
                send_idle_pct = 72;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            pick = $urandom_range(99);
            if (pick < 40) begin
                write_all(rand64(), rand64(), rand64(), rand64(), rand64());
            end else if (pick < 70) begin
                write_reg(3'($urandom_range(7)), rand64());
                cfg_valid <= 1'b0;
            end else if (pick < 75) begin
                write_all('0, '0, '0, '0, '0);
            end else if (pick < 80) begin
                write_all('1, '1, '1, '1, '1);
            end

            // mostly multi-block runs, a few short ones
            run_len = ($urandom_range(3) == 0) ? $urandom_range(1, 20)
                                               : $urandom_range(60, 200);
            if (run_len > RANDOM_BYTES - sent)
                run_len = RANDOM_BYTES - sent;
            for (int i = 0; i < run_len; i++)
                pending_bytes.push_back(rand_byte());
            sent += run_len;
            drain();
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("chacha20_keystream_xor_tb OK");
        end else begin
            $display("chacha20_keystream_xor_tb NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
rtl/cc20_pkg.sv
rtl/cc20_ram.sv
rtl/cc20_core.sv
rtl/chacha20_keystream_xor.sv
bench/chacha20_keystream_xor_tb.sv
